[rtl/sdd_pkg.sv]
// Shared types, constants and command/status structures for the sidechain ducking detector.
`timescale 1ns / 1ps
`default_nettype none

package sdd_pkg;

    // Field and datapath widths.
    localparam int unsigned SMP_W     = 24;  // Q1.23 samples, gains, levels
    localparam int unsigned COEF_W    = 24;  // Q0.24 coefficients
    localparam int unsigned HP_W      = 25;  // saturated high-pass output
    localparam int unsigned ENV_W     = 25;  // envelope and detector level
    localparam int unsigned KEND_W    = 26;  // upper knee edge, knee width
    localparam int unsigned OP_W      = 27;  // signed multiplier operands
    localparam int unsigned PROD_W    = 54;  // signed product
    localparam int unsigned RND_W     = 30;  // rounded product
    localparam int unsigned Q_BITS    = 24;  // quotient bits of the knee division
    localparam int unsigned CNT_W     = 5;   // divider step counter
    localparam int unsigned CFG_IDX_W = 3;   // configuration register index

    // Arithmetic constants.
    localparam logic signed [OP_W-1:0]   K_UNITY     = 27'sd8388608;   // 1.0 in Q1.23
    localparam logic signed [OP_W-1:0]   K_THREE_ONE = 27'sd50331648;  // 3.0 in Q2.24
    localparam logic signed [OP_W-1:0]   K_RELAX     = 27'sd335544;    // 0.02 in Q0.24
    localparam logic signed [OP_W-1:0]   K_KNEE_UP   = 27'sd33474947;  // +6 dB in Q2.24
    localparam logic signed [OP_W-1:0]   K_KNEE_DOWN = 27'sd8408526;   // -6 dB in Q0.24
    localparam logic signed [PROD_W-1:0] K_HALF_LSB  = 54'sd8388608;   // rounding offset
    localparam logic signed [RND_W-1:0]  K_HP_MAX    = 30'sd16777215;
    localparam logic signed [RND_W-1:0]  K_HP_MIN    = -30'sd16777216;
    localparam logic signed [RND_W-1:0]  K_ACT_ONE   = 30'sd16777216;  // 1.0 in Q0.24
    localparam logic signed [RND_W-1:0]  K_GAIN_MAX  = 30'sd16777215;
    localparam logic [KEND_W-1:0]        K_MIN_WIDTH = 26'd8;          // 1e-6 in Q1.23
    localparam logic [SMP_W-1:0]         K_GAIN_RST  = 24'd8388608;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DUCK_ENABLE = 3'd0,
        CFG_HPF_COEF    = 3'd1,
        CFG_ATTACK_COEF = 3'd2,
        CFG_RELEASE_COEF= 3'd3,
        CFG_THRESHOLD   = 3'd4,
        CFG_MIN_GAIN    = 3'd5
    } t_cfg_idx;

    // Configuration register contents.
    typedef struct packed {
        logic              duck_enable;
        logic [COEF_W-1:0] hpf_coef;
        logic [COEF_W-1:0] attack_coef;
        logic [COEF_W-1:0] release_coef;
        logic [SMP_W-1:0]  threshold;
        logic [SMP_W-1:0]  min_gain;
    } t_cfg;

    // Operand pair fed to the shared multiplier.
    typedef enum logic [3:0] {
        MUL_HP    = 4'd0,
        MUL_KS    = 4'd1,
        MUL_ENV   = 4'd2,
        MUL_KE    = 4'd3,
        MUL_N2    = 4'd4,
        MUL_ACT   = 4'd5,
        MUL_TGT   = 4'd6,
        MUL_GAIN  = 4'd7,
        MUL_RELAX = 4'd8
    } t_mul_op;

    // Destination of the rounded product.
    typedef enum logic [3:0] {
        WB_NONE     = 4'd0,
        WB_HP       = 4'd1,
        WB_KS       = 4'd2,
        WB_ENV      = 4'd3,
        WB_KE       = 4'd4,
        WB_N2       = 4'd5,
        WB_ACT      = 4'd6,
        WB_ACT_ONE  = 4'd7,
        WB_ACT_ZERO = 4'd8,
        WB_TGT      = 4'd9,
        WB_GAIN     = 4'd10,
        WB_RELAX    = 4'd11
    } t_wb;

    // Commands from the controller.
    typedef struct packed {
        logic    load_in;
        logic    mul_en;
        t_mul_op mul_op;
        t_wb     wb;
        logic    div_start;
        logic    out_load;
    } t_dp_cmd;

    // Status returned by the datapath.
    typedef struct packed {
        logic duck_enable;
        logic env_ge_end;
        logic env_gt_start;
        logic div_done;
    } t_dp_status;

endpackage

`default_nettype wire

[rtl/sidechain_ducking_detector.sv]
// Top level: stream ports, configuration registers, output register, controller and datapath.
// Output valid rises after the relax path with ducking off, or after the detector path with
// ducking on; inside the knee the detector path also runs the bit-serial knee division.
// A word is taken only in the idle state, so an item is finished before the next is accepted;
// a gain that the sink does not take holds the controller until the output register frees.
// Synchronous active-low reset clears the filter and envelope state, sets the gain to unity
// and loads the configuration registers with their default values.
`timescale 1ns / 1ps
`default_nettype none

module sidechain_ducking_detector (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [2*sdd_pkg::SMP_W-1:0]       i_s_axis_tdata,  // side_left, side_right
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    output logic [sdd_pkg::SMP_W-1:0]              o_m_axis_tdata,  // duck_gain
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [sdd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [sdd_pkg::SMP_W-1:0]         i_cfg_data
);
    import sdd_pkg::*;

    t_cfg             r_cfg;
    logic             r_out_valid;
    logic [SMP_W-1:0] r_out_data;

    t_dp_cmd          w_cmd;
    t_dp_status       w_status;
    logic [SMP_W-1:0] w_gain;
    logic             w_out_free;

    // Configuration register file, always ready.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duck_enable  <= 1'b0;
            r_cfg.hpf_coef     <= 24'd16558000;
            r_cfg.attack_coef  <= 24'd16000000;
            r_cfg.release_coef <= 24'd16770000;
            r_cfg.threshold    <= 24'd838861;
            r_cfg.min_gain     <= 24'd2097152;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DUCK_ENABLE:  r_cfg.duck_enable  <= i_cfg_data[0];
                CFG_HPF_COEF:     r_cfg.hpf_coef     <= i_cfg_data;
                CFG_ATTACK_COEF:  r_cfg.attack_coef  <= i_cfg_data;
                CFG_RELEASE_COEF: r_cfg.release_coef <= i_cfg_data;
                CFG_THRESHOLD:    r_cfg.threshold    <= i_cfg_data;
                CFG_MIN_GAIN:     r_cfg.min_gain     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Output register: refilled as soon as the held word is taken.
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            r_out_data <= w_gain;
        end
    end
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    sdd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .i_out_free (w_out_free),
        .o_cmd      (w_cmd)
    );

    sdd_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd        (w_cmd),
        .i_side_left  ($signed(i_s_axis_tdata[SMP_W-1:0])),
        .i_side_right ($signed(i_s_axis_tdata[2*SMP_W-1:SMP_W])),
        .o_status     (w_status),
        .o_gain       (w_gain)
    );

endmodule

`default_nettype wire

[rtl/sdd_div.sv]
// Restoring divider, one quotient bit per cycle, for the knee position.
`timescale 1ns / 1ps
`default_nettype none

module sdd_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [sdd_pkg::KEND_W-1:0]  i_dividend,  // must be below the divisor
    input  wire logic [sdd_pkg::KEND_W-1:0]  i_divisor,
    output logic                             o_done,
    output logic [sdd_pkg::Q_BITS-1:0]       o_quotient
);
    import sdd_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [KEND_W:0]   r_rem;
    logic [KEND_W-1:0] r_den;
    logic [Q_BITS-1:0] r_quo;

    logic [KEND_W:0]   w_shift;
    logic [KEND_W:0]   w_diff;
    logic              w_ge;

    // One trial subtraction per cycle.
    assign w_shift = {r_rem[KEND_W-1:0], 1'b0};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_diff  = w_shift - {1'b0, r_den};

    // Step control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(Q_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_dividend};
            r_den <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff : w_shift;
            r_quo <= {r_quo[Q_BITS-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

[rtl/sdd_datapath.sv]
// Datapath: detector state, shared multiplier with rounding, knee logic and divider.
`timescale 1ns / 1ps
`default_nettype none

module sdd_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire sdd_pkg::t_cfg                     i_cfg,
    input  wire sdd_pkg::t_dp_cmd                  i_cmd,
    input  wire logic signed [sdd_pkg::SMP_W-1:0]  i_side_left,
    input  wire logic signed [sdd_pkg::SMP_W-1:0]  i_side_right,
    output sdd_pkg::t_dp_status                    o_status,
    output logic [sdd_pkg::SMP_W-1:0]              o_gain
);
    import sdd_pkg::*;

    // Filter, envelope and gain state.
    logic signed [SMP_W-1:0]  r_mono;
    logic signed [SMP_W-1:0]  r_hp_in;
    logic signed [HP_W-1:0]   r_hp_out;
    logic [ENV_W-1:0]         r_det;
    logic [ENV_W-1:0]         r_env;
    logic [ENV_W-1:0]         r_kstart;
    logic [KEND_W-1:0]        r_kend;
    logic [ENV_W-1:0]         r_n2;
    logic [ENV_W-1:0]         r_act;
    logic signed [KEND_W-1:0] r_target;
    logic [SMP_W-1:0]         r_gain;
    logic signed [PROD_W-1:0] r_prod;

    logic signed [SMP_W:0]    w_lr_sum;
    logic signed [OP_W-1:0]   w_op_a;
    logic signed [OP_W-1:0]   w_op_b;
    logic signed [PROD_W-1:0] w_prod_rnd;
    logic signed [RND_W-1:0]  w_rnd;
    logic signed [HP_W-1:0]   w_hp_sat;
    logic [ENV_W-1:0]         w_hp_abs;
    logic signed [RND_W-1:0]  w_env_sum;
    logic signed [RND_W-1:0]  w_gain_base;
    logic signed [RND_W-1:0]  w_gain_sum;
    logic [SMP_W-1:0]         w_gain_clamp;
    logic [ENV_W-1:0]         w_act_clamp;
    logic signed [RND_W-1:0]  w_target_sum;
    logic [COEF_W-1:0]        w_env_coef;
    logic [COEF_W-1:0]        w_gain_coef;
    logic [KEND_W-1:0]        w_width_raw;
    logic [KEND_W-1:0]        w_width;
    logic [KEND_W-1:0]        w_excess;
    logic                     w_div_done;
    logic [Q_BITS-1:0]        w_quot;

    // Mono mix, floor of the half sum.
    assign w_lr_sum = (SMP_W+1)'(i_side_left) + (SMP_W+1)'(i_side_right);

    // Coefficient choice: attack while the envelope rises, and while the gain falls toward its target.
    assign w_env_coef  = (r_det > r_env) ? i_cfg.attack_coef : i_cfg.release_coef;
    assign w_gain_coef = (r_target < $signed({2'b00, r_gain})) ?
                         i_cfg.attack_coef : i_cfg.release_coef;

    // Operand selection for the shared multiplier.
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        unique case (i_cmd.mul_op)
            MUL_HP: begin
                w_op_a = $signed(OP_W'(i_cfg.hpf_coef));
                w_op_b = OP_W'(r_hp_out) + OP_W'(r_mono) - OP_W'(r_hp_in);
            end
            MUL_KS: begin
                w_op_a = $signed(OP_W'(i_cfg.threshold));
                w_op_b = K_KNEE_DOWN;
            end
            MUL_ENV: begin
                w_op_a = $signed(OP_W'(w_env_coef));
                w_op_b = $signed(OP_W'(r_env)) - $signed(OP_W'(r_det));
            end
            MUL_KE: begin
                w_op_a = $signed(OP_W'(i_cfg.threshold));
                w_op_b = K_KNEE_UP;
            end
            MUL_N2: begin
                w_op_a = $signed(OP_W'(w_quot));
                w_op_b = $signed(OP_W'(w_quot));
            end
            MUL_ACT: begin
                w_op_a = $signed(OP_W'(r_n2));
                w_op_b = K_THREE_ONE - $signed(OP_W'({w_quot, 1'b0}));
            end
            MUL_TGT: begin
                w_op_a = $signed(OP_W'(r_act));
                w_op_b = $signed(OP_W'(i_cfg.min_gain)) - K_UNITY;
            end
            MUL_GAIN: begin
                w_op_a = $signed(OP_W'(w_gain_coef));
                w_op_b = $signed(OP_W'(r_gain)) - OP_W'(r_target);
            end
            MUL_RELAX: begin
                w_op_a = K_RELAX;
                w_op_b = K_UNITY - $signed(OP_W'(r_gain));
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    // Product register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= w_op_a * w_op_b;
        end
    end

    // Round to nearest, halves upward, dropping 24 fraction bits.
    assign w_prod_rnd = (r_prod + K_HALF_LSB) >>> 24;
    assign w_rnd      = w_prod_rnd[RND_W-1:0];

    // High-pass saturation and magnitude.
    always_comb begin
        if (w_rnd > K_HP_MAX) begin
            w_hp_sat = K_HP_MAX[HP_W-1:0];
        end else if (w_rnd < K_HP_MIN) begin
            w_hp_sat = K_HP_MIN[HP_W-1:0];
        end else begin
            w_hp_sat = w_rnd[HP_W-1:0];
        end
    end
    assign w_hp_abs = w_hp_sat[HP_W-1] ? ENV_W'(-w_hp_sat) : ENV_W'(w_hp_sat);

    // Envelope and target sums.
    assign w_env_sum    = $signed(RND_W'(r_det)) + w_rnd;
    assign w_target_sum = RND_W'(K_UNITY) + w_rnd;

    // Activity clamped to [0, 1].
    always_comb begin
        if (w_rnd < 0) begin
            w_act_clamp = '0;
        end else if (w_rnd > K_ACT_ONE) begin
            w_act_clamp = K_ACT_ONE[ENV_W-1:0];
        end else begin
            w_act_clamp = w_rnd[ENV_W-1:0];
        end
    end

    // Gain update, clamped to the output range.
    assign w_gain_base = (i_cmd.wb == WB_RELAX) ? $signed(RND_W'(r_gain)) :
                                                   RND_W'(r_target);
    assign w_gain_sum  = w_gain_base + w_rnd;
    always_comb begin
        if (w_gain_sum < 0) begin
            w_gain_clamp = '0;
        end else if (w_gain_sum > K_GAIN_MAX) begin
            w_gain_clamp = K_GAIN_MAX[SMP_W-1:0];
        end else begin
            w_gain_clamp = w_gain_sum[SMP_W-1:0];
        end
    end

    // Knee width with its lower bound, and the envelope position inside the knee.
    assign w_width_raw = r_kend - KEND_W'(r_kstart);
    assign w_width     = (w_width_raw < K_MIN_WIDTH) ? K_MIN_WIDTH : w_width_raw;
    assign w_excess    = KEND_W'(r_env - r_kstart);

    sdd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_excess),
        .i_divisor  (w_width),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // Filter, envelope and gain state; reset clears the filter and envelope and sets the gain to unity.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp_in  <= '0;
            r_hp_out <= '0;
            r_env    <= '0;
            r_gain   <= K_GAIN_RST;
        end else begin
            unique case (i_cmd.wb)
                WB_HP: begin
                    r_hp_in  <= r_mono;
                    r_hp_out <= w_hp_sat;
                end
                WB_ENV:   r_env  <= w_env_sum[ENV_W-1:0];
                WB_GAIN,
                WB_RELAX: r_gain <= w_gain_clamp;
                default: begin
                end
            endcase
        end
    end

    // Per-item working values.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mono <= w_lr_sum[SMP_W:1];
        end
        unique case (i_cmd.wb)
            WB_HP:       r_det    <= w_hp_abs;
            WB_KS:       r_kstart <= w_rnd[ENV_W-1:0];
            WB_KE:       r_kend   <= w_rnd[KEND_W-1:0];
            WB_N2:       r_n2     <= w_rnd[ENV_W-1:0];
            WB_ACT:      r_act    <= w_act_clamp;
            WB_ACT_ONE:  r_act    <= K_ACT_ONE[ENV_W-1:0];
            WB_ACT_ZERO: r_act    <= '0;
            WB_TGT:      r_target <= w_target_sum[KEND_W-1:0];
            default: begin
            end
        endcase
    end

    // Status toward the controller.
    always_comb begin
        o_status.duck_enable  = i_cfg.duck_enable;
        o_status.env_ge_end   = KEND_W'(r_env) >= r_kend;
        o_status.env_gt_start = r_env > r_kstart;
        o_status.div_done     = w_div_done;
    end

    assign o_gain = r_gain;

endmodule

`default_nettype wire

[rtl/sdd_ctrl.sv]
// Controller: sequences the multiplier, the divider and the result hand-off per item.
`timescale 1ns / 1ps
`default_nettype none

module sdd_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire sdd_pkg::t_dp_status i_status,
    input  wire logic                i_out_free,
    output sdd_pkg::t_dp_cmd         o_cmd
);
    import sdd_pkg::*;

    localparam int unsigned ST_W = 5;
    localparam logic [ST_W-1:0] S_IDLE  = 5'd0;
    localparam logic [ST_W-1:0] S_HP    = 5'd1;
    localparam logic [ST_W-1:0] S_HPW   = 5'd2;
    localparam logic [ST_W-1:0] S_ENV   = 5'd3;
    localparam logic [ST_W-1:0] S_ENVW  = 5'd4;
    localparam logic [ST_W-1:0] S_KEW   = 5'd5;
    localparam logic [ST_W-1:0] S_CMP   = 5'd6;
    localparam logic [ST_W-1:0] S_DIV   = 5'd7;
    localparam logic [ST_W-1:0] S_N2    = 5'd8;
    localparam logic [ST_W-1:0] S_N2W   = 5'd9;
    localparam logic [ST_W-1:0] S_ACTW  = 5'd10;
    localparam logic [ST_W-1:0] S_TGT   = 5'd11;
    localparam logic [ST_W-1:0] S_TGTW  = 5'd12;
    localparam logic [ST_W-1:0] S_GAIN  = 5'd13;
    localparam logic [ST_W-1:0] S_GAINW = 5'd14;
    localparam logic [ST_W-1:0] S_RELAX = 5'd15;
    localparam logic [ST_W-1:0] S_RELW  = 5'd16;
    localparam logic [ST_W-1:0] S_OUT   = 5'd17;
    localparam logic [ST_W-1:0] S_ACT   = 5'd18;

    logic [ST_W-1:0] r_state;
    logic [ST_W-1:0] n_state;

    // Next state and commands.
    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd.load_in    = 1'b0;
        o_cmd.mul_en     = 1'b0;
        o_cmd.mul_op     = MUL_HP;
        o_cmd.wb         = WB_NONE;
        o_cmd.div_start  = 1'b0;
        o_cmd.out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = i_status.duck_enable ? S_HP : S_RELAX;
                end
            end
            S_HP: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_HP;
                n_state      = S_HPW;
            end
            S_HPW: begin
                o_cmd.wb     = WB_HP;
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_KS;
                n_state      = S_ENV;
            end
            S_ENV: begin
                o_cmd.wb     = WB_KS;
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_ENV;
                n_state      = S_ENVW;
            end
            S_ENVW: begin
                o_cmd.wb     = WB_ENV;
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_KE;
                n_state      = S_KEW;
            end
            S_KEW: begin
                o_cmd.wb = WB_KE;
                n_state  = S_CMP;
            end
            // Above the knee, inside it, or below it.
            S_CMP: begin
                priority if (i_status.env_ge_end) begin
                    o_cmd.wb = WB_ACT_ONE;
                    n_state  = S_TGT;
                end else if (i_status.env_gt_start) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.wb = WB_ACT_ZERO;
                    n_state  = S_TGT;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_N2;
                end
            end
            S_N2: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_N2;
                n_state      = S_N2W;
            end
            // The squared position must be stored before the activity product reads it.
            S_N2W: begin
                o_cmd.wb = WB_N2;
                n_state  = S_ACT;
            end
            S_ACT: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_ACT;
                n_state      = S_ACTW;
            end
            S_ACTW: begin
                o_cmd.wb = WB_ACT;
                n_state  = S_TGT;
            end
            S_TGT: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_TGT;
                n_state      = S_TGTW;
            end
            S_TGTW: begin
                o_cmd.wb = WB_TGT;
                n_state  = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_GAIN;
                n_state      = S_GAINW;
            end
            S_GAINW: begin
                o_cmd.wb = WB_GAIN;
                n_state  = S_OUT;
            end
            S_RELAX: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_RELAX;
                n_state      = S_RELW;
            end
            S_RELW: begin
                o_cmd.wb = WB_RELAX;
                n_state  = S_OUT;
            end
            // Hand the gain to the output register once it has room.
            S_OUT: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A result is handed over only into a free output register.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_out_free)
        else $error("result loaded into a full output register");

    // The divider reports completion only while the controller waits for it.
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

    // An accepted word starts either the detector path or the relax path.
    a_accept_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_HP || r_state == S_RELAX))
        else $error("accepted word did not start a computation");

endmodule

`default_nettype wire
